/* src/scng_pkg.sv */
// Shared types, codes and constants of the sound chip noise generator.
// No dependencies; used by scng_gen, the top level and the testbench.
package scng_pkg;

	localparam int unsigned WordW = 32;

	localparam logic [WordW-1:0] StepBase  = 32'd128000000;  // 31250 << 12
	localparam logic [WordW-1:0] RateBase  = 32'd44100;
	localparam logic [WordW-1:0] SeedReset = 32'h1111_1111;
	localparam logic [WordW-1:0] LcgMul    = 32'd110351245;
	localparam logic [WordW-1:0] LcgAdd    = 32'd12345;
	localparam logic [WordW-1:0] TapMask   = 32'h4000_0004;
	localparam logic [WordW-1:0] HalfWord  = 32'h8000_0000;

	localparam logic [1:0] SrcExternal = 2'd3;
	localparam logic [1:0] RateReset   = 2'd2;
	localparam logic [1:0] RateMax     = 2'd2;
	localparam logic [3:0] RateShift0  = 4'd12;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_TRIGGER = 2'd1,
		ACT_SYNC    = 2'd2,
		ACT_RESEED  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_SOURCE  = 2'd0,
		REG_RATE    = 2'd1,
		REG_VARIANT = 2'd2,
		REG_NONE    = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_SUB,
		ST_FIN
	} state_t;

endpackage

/* src/scng_gen.sv */
// One advance of the noise generator word, congruential or shift register.
// Depends on scng_pkg.
module scng_gen (
	input  logic [scng_pkg::WordW-1:0] word,
	input  logic                       variant,
	input  logic                       held,
	output logic [scng_pkg::WordW-1:0] next_word,
	output logic                       next_held
);
	import scng_pkg::*;

	logic [WordW-1:0] taps;
	logic [WordW-1:0] lcg_word;
	logic             fb;

	assign taps     = word & TapMask;
	assign fb       = (taps != '0) && (taps != TapMask);
	assign lcg_word = word * LcgMul + LcgAdd;

	always_comb begin
		if (!variant) begin
			next_held = (word > HalfWord);
			next_word = lcg_word;
		end else begin
			next_held = held;
			next_word = {word[WordW-2:0], fb};
		end
	end

endmodule

/* src/sound_chip_noise_generator.sv */
// Top level of the sound chip noise generator: sequencer, phase counter, result register.
// Depends on scng_pkg and scng_gen.
//
// Every input transaction returns one level bit. Trigger, sync and reseed items pass from
// the idle state straight to the finish state. A sample tick makes n generator advances
// (0 to 3 with the modes in range), unless synced or on the external source: the phase
// counter goes through one shared 32-bit adder/subtractor, once to add the step and then
// once per threshold compare-and-subtract. The input is not ready while an item is at work,
// while the previous result has not been taken or while a configuration write is offered.
// Configuration writes are taken while the sequencer is idle.
module sound_chip_noise_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 action,
	input  logic                       sync_on,
	input  logic [scng_pkg::WordW-1:0] seed_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       level,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [1:0]                 cfg_data
);
	import scng_pkg::*;

	state_t state_q, state_d;

	logic [1:0]       source_q;
	logic [1:0]       rate_q;
	logic             variant_q;
	logic [WordW-1:0] phase_q;
	logic [WordW-1:0] word_q;
	logic             held_q;
	logic             sync_q;
	logic             out_valid_q;
	logic             level_q;

	logic             in_fire, cfg_fire, out_fire;
	logic [WordW-1:0] threshold, step, operand;
	logic [WordW:0]   alu_res;
	logic             alu_sub;
	logic             below;
	logic [WordW-1:0] gen_next_word;
	logic             gen_next_held;
	logic [1:0]       rate_new;

	// a pending configuration write goes first
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign level     = level_q;

	assign threshold = RateBase << (RateShift0 - {2'b00, rate_q});
	assign step      = StepBase >> source_q;
	assign rate_new  = (cfg_data > RateMax) ? RateMax : cfg_data;

	// Shared adder/subtractor; the borrow out doubles as the threshold compare
	assign alu_sub = (state_q == ST_SUB);
	assign operand = alu_sub ? threshold : step;
	assign alu_res = alu_sub ? ({1'b0, phase_q} - {1'b0, operand})
	                         : ({1'b0, phase_q} + {1'b0, operand});
	assign below   = alu_sub && alu_res[WordW];

	scng_gen u_gen (
		.word      (word_q),
		.variant   (variant_q),
		.held      (held_q),
		.next_word (gen_next_word),
		.next_held (gen_next_held)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (action_t'(action) == ACT_TICK && !sync_q && source_q != SrcExternal) begin
						state_d = ST_ADD;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_ADD: begin
				state_d = ST_SUB;
			end
			ST_SUB: begin
				if (below) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q    <= '0;
			rate_q      <= RateReset;
			variant_q   <= 1'b0;
			phase_q     <= '0;
			word_q      <= SeedReset;
			held_q      <= 1'b0;
			sync_q      <= 1'b0;
			out_valid_q <= 1'b0;
			level_q     <= 1'b0;
		end else begin
			if (out_fire) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				unique case (reg_index_t'(cfg_index))
					REG_SOURCE:  source_q  <= cfg_data;
					REG_RATE: begin
						// rescale the stored counter to the new threshold
						if (rate_new < rate_q) begin
							phase_q <= phase_q << (rate_q - rate_new);
						end else begin
							phase_q <= phase_q >> (rate_new - rate_q);
						end
						rate_q <= rate_new;
					end
					REG_VARIANT: variant_q <= cfg_data[0];
					REG_NONE:    ;
					default:     ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (action_t'(action))
							ACT_TRIGGER: begin
								if (source_q == SrcExternal) begin
									word_q <= gen_next_word;
									held_q <= gen_next_held;
								end
							end
							ACT_SYNC: begin
								if (sync_on) begin
									phase_q <= '0;
								end
								sync_q <= sync_on;
							end
							ACT_RESEED: word_q <= seed_value;
							default: ;
						endcase
					end
				end
				ST_ADD: begin
					phase_q <= alu_res[WordW-1:0];
				end
				ST_SUB: begin
					if (!below) begin
						phase_q <= alu_res[WordW-1:0];
						word_q  <= gen_next_word;
						held_q  <= gen_next_held;
					end
				end
				ST_FIN: begin
					out_valid_q <= 1'b1;
					level_q     <= variant_q ? word_q[0] : held_q;
				end
				default: ;
			endcase
		end
	end

endmodule

/* src/scng_chk.sv */
// Port-level checker for sound_chip_noise_generator, attached by the bind below.
// Depends on the top level's ports only.
module scng_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic level,
	input logic cfg_ready
);

	// an accepted item keeps the input closed for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transaction");

	// no new item while an untaken result is held
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid || out_ready)
		else $error("input accepted over a pending result");

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level))
		else $error("stalled result changed or dropped");

	// input ready only while the sequencer is idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cfg_ready)
		else $error("input ready while busy");

endmodule

bind sound_chip_noise_generator scng_chk u_scng_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.level     (level),
	.cfg_ready (cfg_ready)
);

/* dv/testbench.sv */
// Testbench for sound_chip_noise_generator: directed and random transactions checked
// against an in-bench model of the phase counter and noise generator.
// Depends on scng_pkg and the RTL in src.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import scng_pkg::*;

	localparam int unsigned CycleLimit = 400000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       action;
	logic             sync_on;
	logic [WordW-1:0] seed_value;
	logic             out_valid;
	logic             out_ready;
	logic             level;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [1:0]       cfg_data;

	// model state and register copies
	logic [1:0]       src_mode;
	logic [1:0]       rate_sel;
	logic             variant_sel;
	logic [WordW-1:0] phase_acc;
	logic [WordW-1:0] noise_word;
	logic             lcg_level;
	logic             sync_hold;

	logic             pending_levels[$];
	logic             expected_bit;
	int unsigned      fail_count;
	int unsigned      cycle_count;
	bit               steady;

	sound_chip_noise_generator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.sync_on    (sync_on),
		.seed_value (seed_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.level      (level),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void advance_noise();
		logic [WordW-1:0] taps;
		if (!variant_sel) begin
			lcg_level  = (noise_word > HalfWord);
			noise_word = noise_word * LcgMul + LcgAdd;
		end else begin
			taps       = noise_word & TapMask;
			noise_word = {noise_word[WordW-2:0], (taps != '0 && taps != TapMask)};
		end
	endfunction

	function automatic logic predict_level(action_t act, logic hold, logic [WordW-1:0] seed);
		logic [WordW-1:0] threshold;
		case (act)
			ACT_TICK: begin
				if (!sync_hold && src_mode != SrcExternal) begin
					threshold = RateBase << (RateShift0 - {2'b00, rate_sel});
					phase_acc = phase_acc + (StepBase >> src_mode);
					while (phase_acc >= threshold) begin
						phase_acc = phase_acc - threshold;
						advance_noise();
					end
				end
			end
			ACT_TRIGGER: begin
				if (src_mode == SrcExternal)
					advance_noise();
			end
			ACT_SYNC: begin
				if (hold)
					phase_acc = '0;
				sync_hold = hold;
			end
			default: noise_word = seed;
		endcase
		return variant_sel ? noise_word[0] : lcg_level;
	endfunction

	function automatic void note_reg_write(reg_index_t idx, logic [1:0] data);
		logic [1:0] new_rate;
		case (idx)
			REG_SOURCE:  src_mode = data;
			REG_RATE: begin
				new_rate = (data > RateMax) ? RateMax : data;
				if (new_rate < rate_sel)
					phase_acc = phase_acc << (rate_sel - new_rate);
				else
					phase_acc = phase_acc >> (new_rate - rate_sel);
				rate_sel = new_rate;
			end
			REG_VARIANT: variant_sel = data[0];
			default: ;
		endcase
	endfunction

	// Leaves in_valid high after acceptance; whoever stops sending must drop it.
	task automatic send_item(action_t act, logic hold, logic [WordW-1:0] seed);
		int unsigned gap;
		@(negedge clk);
		if (!steady && $urandom_range(0, 99) < 14) begin
			gap      = $urandom_range(1, 4);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   = 1'b1;
		action     = act;
		sync_on    = hold;
		seed_value = seed;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_levels.push_back(predict_level(act, hold, seed));
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [1:0] data);
		wait_results_done();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		note_reg_write(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_internal_ticks();
		// reset modes: two advances on the first tick, three on the second
		repeat (2) send_item(ACT_TICK, 1'($urandom_range(0, 1)), $urandom);
		write_reg(REG_RATE, 2'd0);
		write_reg(REG_SOURCE, 2'd2);
		repeat (2) send_item(ACT_TICK, 1'($urandom_range(0, 1)), $urandom);
		// rate value 3 saturates to rate 2, the fastest rate
		write_reg(REG_RATE, 2'd3);
		write_reg(REG_SOURCE, 2'd1);
		repeat (2) send_item(ACT_TICK, 1'($urandom_range(0, 1)), $urandom);
	endtask

	task automatic test_sync_hold();
		send_item(ACT_SYNC, 1'b1, $urandom);
		send_item(ACT_TICK, 1'b0, $urandom);
		send_item(ACT_TRIGGER, 1'b1, $urandom);
		send_item(ACT_SYNC, 1'b0, $urandom);
		send_item(ACT_TICK, 1'b1, $urandom);
	endtask

	task automatic test_external_triggers();
		write_reg(REG_SOURCE, SrcExternal);
		send_item(ACT_TICK, 1'b0, $urandom);
		// level compares strictly greater than the half word
		send_item(ACT_RESEED, 1'b1, HalfWord);
		send_item(ACT_TRIGGER, 1'b0, $urandom);
		send_item(ACT_RESEED, 1'b0, HalfWord + 1);
		send_item(ACT_TRIGGER, 1'b1, $urandom);
		// triggers advance even while synced
		send_item(ACT_SYNC, 1'b1, $urandom);
		send_item(ACT_TRIGGER, 1'b0, $urandom);
		send_item(ACT_SYNC, 1'b0, $urandom);
	endtask

	task automatic test_shift_register();
		write_reg(REG_VARIANT, 2'd1);
		send_item(ACT_RESEED, 1'b0, TapMask);
		send_item(ACT_TRIGGER, 1'b0, $urandom);
		send_item(ACT_RESEED, 1'b1, 32'h0000_0004);
		send_item(ACT_TRIGGER, 1'b1, $urandom);
		send_item(ACT_RESEED, 1'b0, 32'h0000_0000);
		send_item(ACT_TRIGGER, 1'b0, $urandom);
		write_reg(REG_NONE, 2'd3);
		write_reg(REG_VARIANT, 2'd0);
	endtask

	task automatic test_random_phases();
		logic [1:0]  src_pick;
		logic [1:0]  rate_pick;
		logic        var_pick;
		logic        hold;
		int unsigned pick;
		action_t     act;
		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin src_pick = 2'd0; rate_pick = 2'd0; var_pick = 1'b0; end
				1: begin src_pick = 2'd2; rate_pick = 2'd2; var_pick = 1'b1; end
				2: begin src_pick = SrcExternal; rate_pick = 2'd1; var_pick = 1'b0; end
				default: begin
					src_pick  = ($urandom_range(0, 3) == 0) ? SrcExternal
						: 2'($urandom_range(0, 2));
					rate_pick = 2'($urandom_range(0, 3));
					var_pick  = 1'($urandom_range(0, 1));
				end
			endcase
			write_reg(REG_SOURCE, src_pick);
			write_reg(REG_VARIANT, {1'b0, var_pick});
			write_reg(REG_RATE, rate_pick);
			steady = (phase == 3);
			for (int n = 0; n < 85; n++) begin
				if (phase == 5 && n == 40)
					wait_results_done();
				pick = $urandom_range(0, 99);
				if (src_mode == SrcExternal)
					act = (pick < 60) ? ACT_TRIGGER : (pick < 80) ? ACT_TICK
						: (pick < 90) ? ACT_RESEED : ACT_SYNC;
				else
					act = (pick < 70) ? ACT_TICK : (pick < 80) ? ACT_TRIGGER
						: (pick < 90) ? ACT_RESEED : ACT_SYNC;
				// keep sync holds short so ticks get through
				if (act == ACT_SYNC)
					hold = sync_hold ? ($urandom_range(0, 99) < 20)
						: ($urandom_range(0, 99) < 60);
				else
					hold = 1'($urandom_range(0, 1));
				send_item(act, hold, $urandom);
			end
		end
		steady = 1'b0;
	endtask

	always @(negedge clk)
		out_ready = steady || ($urandom_range(0, 99) >= 14);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				$error("unexpected transaction: level %0b with nothing pending", level);
				fail_count++;
			end else begin
				expected_bit = pending_levels.pop_front();
				if (level !== expected_bit) begin
					$error("level mismatch: expected %0b, actual %0b", expected_bit, level);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = ACT_TICK;
		sync_on     = 1'b0;
		seed_value  = '0;
		out_ready   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_SOURCE;
		cfg_data    = '0;
		steady      = 1'b0;
		fail_count  = 0;
		cycle_count = 0;
		src_mode    = 2'd0;
		rate_sel    = RateReset;
		variant_sel = 1'b0;
		phase_acc   = '0;
		noise_word  = SeedReset;
		lcg_level   = 1'b0;
		sync_hold   = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_internal_ticks();
		test_sync_hold();
		test_external_triggers();
		test_shift_register();
		test_random_phases();

		wait_results_done();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* files.f */
src/scng_pkg.sv
src/scng_gen.sv
src/sound_chip_noise_generator.sv
src/scng_chk.sv
dv/testbench.sv
